@@ rtl/core/esc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Types, character codes and helper functions for the escape sequence decoder.
// ----------------------------------------------------------------------------
package esc_pkg;

	localparam logic [7:0] TERM_RESET = 8'd34;
	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_N       = 8'h6E;
	localparam logic [7:0] CH_R       = 8'h72;
	localparam logic [7:0] CH_B       = 8'h62;
	localparam logic [7:0] CH_F       = 8'h66;
	localparam logic [7:0] CH_T       = 8'h74;
	localparam logic [7:0] CH_V       = 8'h76;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_SEVEN   = 8'h37;
	localparam logic [7:0] PRINT_LO   = 8'h20;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	localparam logic [7:0] VAL_LF = 8'h0A;
	localparam logic [7:0] VAL_CR = 8'h0D;
	localparam logic [7:0] VAL_BS = 8'h08;
	localparam logic [7:0] VAL_FF = 8'h0C;
	localparam logic [7:0] VAL_HT = 8'h09;
	localparam logic [7:0] VAL_VT = 8'h0B;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2,
		MODE_OCT   = 2'd3
	} mode_t;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		mode_t      mode;
		logic [1:0] cnt;
		logic [7:0] acc;
	} state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] value;
		logic       last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
		state_t     nx;
	} dec_t;

	typedef struct packed {
		logic       emit;
		logic       kind;
		logic [7:0] value;
		logic       to_esc;
	} plain_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] val;
	} hex_t;

	function automatic plain_t plain_byte(input logic [7:0] c, input logic [7:0] term);
		plain_t p;
		p = '0;
		if (c == term) begin
			p.emit = 1'b1;
			p.kind = KIND_END;
		end else if (c == CH_BSLASH) begin
			p.to_esc = 1'b1;
		end else if (c inside {[PRINT_LO:PRINT_HI]}) begin
			p.emit  = 1'b1;
			p.kind  = KIND_DATA;
			p.value = c;
		end
		return p;
	endfunction

	function automatic hex_t hex_val(input logic [7:0] c);
		hex_t h;
		h = '0;
		if (c inside {[8'h30:8'h39]}) begin
			h.ok  = 1'b1;
			h.val = c[3:0];
		end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			h.ok  = 1'b1;
			h.val = c[3:0] + 4'd9;
		end
		return h;
	endfunction

endpackage

@@ rtl/core/esc_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_decode
// Next-state and result logic for one raw byte; up to two results per byte.
// ----------------------------------------------------------------------------
module esc_decode
	import esc_pkg::*;
(
	input  state_t     st,
	input  logic [7:0] in_byte,
	input  logic [7:0] term,
	output dec_t       dec
);

	plain_t     p;
	hex_t       h;
	logic [1:0] cnt_inc;
	logic [7:0] hex_acc;
	logic [7:0] oct_acc;
	logic       oct_digit;

	always_comb begin
		p         = plain_byte(in_byte, term);
		h         = hex_val(in_byte);
		cnt_inc   = st.cnt + 2'd1;
		hex_acc   = {st.acc[3:0], h.val};
		oct_acc   = {st.acc[4:0], in_byte[2:0]};
		oct_digit = in_byte inside {[CH_ZERO:CH_SEVEN]};

		dec    = '0;
		dec.nx = st;

		case (st.mode)
			MODE_PLAIN: begin
				if (p.emit) begin
					dec.n        = 2'd1;
					dec.r0.kind  = p.kind;
					dec.r0.value = p.value;
				end
				if (p.to_esc)
					dec.nx.mode = MODE_ESC;
			end
			MODE_ESC: begin
				dec.nx.mode = MODE_PLAIN;
				dec.n       = 2'd1;
				case (in_byte)
					CH_N: dec.r0.value = VAL_LF;
					CH_R: dec.r0.value = VAL_CR;
					CH_B: dec.r0.value = VAL_BS;
					CH_F: dec.r0.value = VAL_FF;
					CH_T: dec.r0.value = VAL_HT;
					CH_V: dec.r0.value = VAL_VT;
					CH_X: begin
						dec.n       = 2'd0;
						dec.nx.mode = MODE_HEX;
						dec.nx.cnt  = 2'd0;
						dec.nx.acc  = 8'd0;
					end
					default: begin
						if (oct_digit) begin
							dec.n       = 2'd0;
							dec.nx.mode = MODE_OCT;
							dec.nx.cnt  = 2'd1;
							dec.nx.acc  = {5'd0, in_byte[2:0]};
						end else begin
							dec.r0.value = in_byte;
						end
					end
				endcase
			end
			MODE_HEX, MODE_OCT: begin
				if ((st.mode == MODE_HEX) ? h.ok : oct_digit) begin
					dec.nx.acc = (st.mode == MODE_HEX) ? hex_acc : oct_acc;
					dec.nx.cnt = cnt_inc;
					if ((st.mode == MODE_HEX) ? (cnt_inc >= 2'd2) : (cnt_inc >= 2'd3)) begin
						dec.n        = 2'd1;
						dec.r0.value = dec.nx.acc;
						dec.nx.mode  = MODE_PLAIN;
						dec.nx.cnt   = 2'd0;
					end
				end else begin
					// escape closed by a non-digit, which is then taken as plain text
					dec.r0.value = st.acc;
					dec.nx.mode  = p.to_esc ? MODE_ESC : MODE_PLAIN;
					dec.nx.cnt   = 2'd0;
					dec.n        = p.emit ? 2'd2 : 2'd1;
					dec.r1.kind  = p.kind;
					dec.r1.value = p.value;
				end
			end
			default: dec.nx.mode = MODE_PLAIN;
		endcase

		dec.r0.last = (dec.n == 2'd1);
		dec.r1.last = 1'b1;
	end

endmodule

@@ rtl/core/esc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_queue
// Result queue taking up to two words per cycle and giving one per cycle.
// ----------------------------------------------------------------------------
module esc_queue
	import esc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [1:0]        push_n,
	input  res_t              r0,
	input  res_t              r1,
	input  logic              pop,
	output res_t              head,
	output logic              room2,
	output logic              nonempty,
	output logic [QCNT_W-1:0] count
);

	res_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_ptr_nx;

	assign wr_ptr_nx = wr_ptr_q + QPTR_W'(1);
	assign head      = mem_q[rd_ptr_q];
	assign nonempty  = (cnt_q != '0);
	assign room2     = (cnt_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push_n != 2'd0)
			mem_q[wr_ptr_q] <= r0;
		if (push_n == 2'd2)
			mem_q[wr_ptr_nx] <= r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push_n) - QCNT_W'(pop);
		end
	end

endmodule

@@ rtl/core/escape_sequence_decoder.sv @@
// An accepted byte is held in the input stage register and decoded from it; its
// result words are written to the result queue, the second one after the first.
// Throughput: one byte per cycle while the result queue has room for two words;
// bytes giving two words limit it to the output rate of one word per cycle, set
// by the result queue.
// Reset: asynchronous, clears decode state, queue and input stage; terminator 34.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_sequence_decoder
// Decodes a quoted string body with C-style escapes into data bytes and an
// end marker.
// ----------------------------------------------------------------------------
module escape_sequence_decoder
	import esc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       kind,
	output logic [7:0] value,
	output logic       last
);

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic [7:0]        term_q;
	state_t            st_q;
	dec_t              dec;
	res_t              head;
	logic              room2;
	logic              advance;
	logic              pop;
	logic [QCNT_W-1:0] qcount;

	assign cfg_ready = 1'b1;
	assign advance   = valid_s1 && room2;
	assign in_stall  = valid_s1 && !room2;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			st_q     <= '{mode: MODE_PLAIN, cnt: 2'd0, acc: 8'd0};
			term_q   <= TERM_RESET;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				st_q <= dec.nx;
			if (cfg_valid && cfg_ready)
				term_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			byte_s1 <= in_byte;
	end

	esc_decode u_decode (
		.st      (st_q),
		.in_byte (byte_s1),
		.term    (term_q),
		.dec     (dec)
	);

	esc_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_n   (advance ? dec.n : 2'd0),
		.r0       (dec.r0),
		.r1       (dec.r1),
		.pop      (pop),
		.head     (head),
		.room2    (room2),
		.nonempty (out_valid),
		.count    (qcount)
	);

	assign kind  = head.kind;
	assign value = head.value;
	assign last  = head.last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qcount <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	a_push_shows: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (dec.n != 2'd0) |=> out_valid)
		else $error("pushed word not visible");

	a_oct_count: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.mode == MODE_OCT |-> st_q.cnt != 2'd0)
		else $error("octal escape without digits");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !room2 |=> valid_s1 && $stable(byte_s1))
		else $error("held byte lost");

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the escape sequence decoder. Streams string bodies
// (plain text, simple, hex and octal escapes, terminators and raw noise)
// under several terminator settings and idle/stall mixes. Each result word
// is compared against a behavioural decode of the accepted bytes.
// ----------------------------------------------------------------------------
module tb_top;
	import esc_pkg::*;

	localparam int QUIET_LIMIT    = 3000;
	localparam int HOLDOFF_CYCLES = 300;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_data  = 8'h00;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte   = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       kind;
	logic [7:0] value;
	logic       last;

	// decoder state mirror
	logic [7:0] term_reg = TERM_RESET;
	mode_t      dec_mode = MODE_PLAIN;
	logic [1:0] dig_cnt  = 2'd0;
	logic [7:0] acc      = 8'h00;

	res_t       decoded_q[$];
	logic [7:0] string_bytes[$];

	logic       byte_taken    = 1'b0;
	int         send_idle_pct = 0;
	int         stall_pct     = 0;
	int         holdoff_reqs  = 0;
	int         holdoff_seen  = 0;
	int         hold_left     = 0;
	int         quiet_cycles  = 0;
	int         mismatches    = 0;

	logic [7:0] esc_letters [0:5] = '{CH_N, CH_R, CH_B, CH_F, CH_T, CH_V};
	logic [7:0] opening_text [0:28] = '{
		PRINT_LO, PRINT_HI, 8'h00, 8'hFF,
		CH_BSLASH, CH_N, CH_BSLASH, CH_R, CH_BSLASH, CH_B,
		CH_BSLASH, CH_F, CH_BSLASH, CH_T, CH_BSLASH, CH_V,
		CH_BSLASH, CH_X, 8'h41, CH_F,
		CH_BSLASH, CH_X, TERM_RESET,
		CH_BSLASH, CH_SEVEN, CH_SEVEN, CH_SEVEN,
		CH_BSLASH, TERM_RESET
	};

	escape_sequence_decoder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.value     (value),
		.last      (last)
	);

	always #5 clk = ~clk;

	function automatic int hex_nibble(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39)
			return int'(c) - 'h30;
		if (c >= 8'h61 && c <= 8'h66)
			return int'(c) - 'h61 + 10;
		if (c >= 8'h41 && c <= 8'h46)
			return int'(c) - 'h41 + 10;
		return -1;
	endfunction

	function automatic void push_word(input logic k, input logic [7:0] v);
		res_t w;
		w.kind  = k;
		w.value = v;
		w.last  = 1'b0;
		decoded_q.push_back(w);
	endfunction

	task automatic plain_char(input logic [7:0] c);
		if (c == term_reg)
			push_word(KIND_END, 8'h00);
		else if (c == CH_BSLASH)
			dec_mode = MODE_ESC;
		else if (c >= PRINT_LO && c <= PRINT_HI)
			push_word(KIND_DATA, c);
	endtask

	task automatic decode_byte(input logic [7:0] c);
		int   base;
		int   d;
		res_t w;
		base = decoded_q.size();
		case (dec_mode)
			MODE_PLAIN: plain_char(c);
			MODE_ESC: begin
				dec_mode = MODE_PLAIN;
				case (c)
					CH_N: push_word(KIND_DATA, VAL_LF);
					CH_R: push_word(KIND_DATA, VAL_CR);
					CH_B: push_word(KIND_DATA, VAL_BS);
					CH_F: push_word(KIND_DATA, VAL_FF);
					CH_T: push_word(KIND_DATA, VAL_HT);
					CH_V: push_word(KIND_DATA, VAL_VT);
					CH_X: begin
						dec_mode = MODE_HEX;
						dig_cnt  = 2'd0;
						acc      = 8'h00;
					end
					default: begin
						if (c >= CH_ZERO && c <= CH_SEVEN) begin
							dec_mode = MODE_OCT;
							dig_cnt  = 2'd1;
							acc      = c - CH_ZERO;
						end else begin
							push_word(KIND_DATA, c);
						end
					end
				endcase
			end
			MODE_HEX: begin
				d = hex_nibble(c);
				if (d >= 0) begin
					acc     = 8'((int'(acc) * 16 + d) & 'hFF);
					dig_cnt = dig_cnt + 2'd1;
					if (dig_cnt >= 2'd2) begin
						push_word(KIND_DATA, acc);
						dec_mode = MODE_PLAIN;
						dig_cnt  = 2'd0;
					end
				end else begin
					push_word(KIND_DATA, acc);
					dec_mode = MODE_PLAIN;
					dig_cnt  = 2'd0;
					plain_char(c);
				end
			end
			default: begin
				if (c >= CH_ZERO && c <= CH_SEVEN) begin
					acc     = 8'((int'(acc) * 8 + int'(c - CH_ZERO)) & 'hFF);
					dig_cnt = dig_cnt + 2'd1;
					if (dig_cnt >= 2'd3) begin
						push_word(KIND_DATA, acc);
						dec_mode = MODE_PLAIN;
						dig_cnt  = 2'd0;
					end
				end else begin
					push_word(KIND_DATA, acc);
					dec_mode = MODE_PLAIN;
					dig_cnt  = 2'd0;
					plain_char(c);
				end
			end
		endcase
		if (decoded_q.size() > base) begin
			w = decoded_q.pop_back();
			w.last = 1'b1;
			decoded_q.push_back(w);
		end
	endtask

	function automatic logic [7:0] random_printable();
		return 8'($urandom_range(PRINT_LO, PRINT_HI));
	endfunction

	// printable text and escapes with random content, terminators, some raw noise
	task automatic add_text(input int count);
		int target;
		int pick;
		int k;
		int r;
		target = string_bytes.size() + count;
		while (string_bytes.size() < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 36) begin
				string_bytes.push_back(random_printable());
			end else if (pick < 48) begin
				string_bytes.push_back(CH_BSLASH);
				string_bytes.push_back(esc_letters[$urandom_range(0, 5)]);
			end else if (pick < 56) begin
				string_bytes.push_back(CH_BSLASH);
				string_bytes.push_back(8'($urandom_range(0, 255)));
			end else if (pick < 68) begin
				string_bytes.push_back(CH_BSLASH);
				string_bytes.push_back(CH_X);
				k = $urandom_range(0, 2);
				repeat (k) begin
					r = $urandom_range(0, 21);
					if (r < 10)
						string_bytes.push_back(8'('h30 + r));
					else if (r < 16)
						string_bytes.push_back(8'('h61 + r - 10));
					else
						string_bytes.push_back(8'('h41 + r - 16));
				end
				string_bytes.push_back(random_printable());
			end else if (pick < 80) begin
				string_bytes.push_back(CH_BSLASH);
				k = $urandom_range(1, 3);
				repeat (k)
					string_bytes.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
				if ($urandom_range(0, 1))
					string_bytes.push_back(CH_SEVEN + 8'($urandom_range(1, 2)));
				else
					string_bytes.push_back(random_printable());
			end else if (pick < 88) begin
				string_bytes.push_back(term_reg);
			end else begin
				string_bytes.push_back(8'($urandom_range(0, 255)));
			end
		end
	endtask

	task automatic wait_drained();
		while (string_bytes.size() != 0 || decoded_q.size() != 0 || in_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_terminator(input logic [7:0] t);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= t;
		do
			@(posedge clk);
		while (!cfg_ready);
		term_reg = t;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin : drive
		logic       offer;
		logic [7:0] b;
		offer = in_valid && !byte_taken;
		b     = in_byte;
		if (!offer && arst_n && string_bytes.size() != 0 &&
				$urandom_range(0, 99) >= send_idle_pct) begin
			offer = 1'b1;
			b     = string_bytes[0];
		end
		in_valid <= offer;
		in_byte  <= b;
	end

	always @(negedge clk) begin : receive
		if (holdoff_reqs != holdoff_seen) begin
			holdoff_seen = holdoff_reqs;
			hold_left    = HOLDOFF_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin : monitor
		res_t want;
		byte_taken <= arst_n && in_valid && !in_stall;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (decoded_q.size() == 0) begin
					mismatches = mismatches + 1;
					if (mismatches <= 10)
						$display("unexpected word: kind %0d value %02h last %0d",
							kind, value, last);
				end else begin
					want = decoded_q.pop_front();
					if (kind !== want.kind || value !== want.value || last !== want.last) begin
						mismatches = mismatches + 1;
						if (mismatches <= 10)
							$display("word mismatch: exp kind %0d value %02h last %0d, got kind %0d value %02h last %0d",
								want.kind, want.value, want.last, kind, value, last);
					end
				end
			end
			if (in_valid && !in_stall) begin
				decode_byte(in_byte);
				string_bytes.delete(0);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAIL escape_sequence_decoder");
			$finish;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (opening_text[i])
			string_bytes.push_back(opening_text[i]);
		add_text(110);
		wait_drained();

		write_terminator(8'h27);
		send_idle_pct = 78;
		add_text(130);
		wait_drained();

		write_terminator(8'h00);
		send_idle_pct = 0;
		stall_pct     = 78;
		add_text(130);
		wait_drained();

		// long receiver hold-off with the sender still busy
		write_terminator(8'hFF);
		send_idle_pct = 7;
		stall_pct     = 7;
		add_text(130);
		holdoff_reqs = holdoff_reqs + 1;
		wait_drained();

		// backslash as terminator: no escapes possible
		write_terminator(CH_BSLASH);
		send_idle_pct = 0;
		stall_pct     = 0;
		add_text(100);
		wait_drained();

		write_terminator(TERM_RESET);
		send_idle_pct = 7;
		stall_pct     = 7;
		add_text(60);
		wait_drained();
		add_text(60);
		wait_drained();

		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("PASS escape_sequence_decoder");
		else
			$display("FAIL escape_sequence_decoder");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/esc_pkg.sv
rtl/core/esc_decode.sv
rtl/core/esc_queue.sv
rtl/core/escape_sequence_decoder.sv
sim/tb_top.sv
